// ===== rtl/pip_pkg.sv =====
package pip_pkg;

  // Item kinds on the input channel
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Vertex count after reset
  localparam logic [3:0] VERTEX_COUNT_RESET = 4'd4;

  // Query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PRIME,
    ST_FETCH,
    ST_MUL_L,
    ST_MUL_R,
    ST_FINISH,
    ST_OUT
  } pip_state_e;

  // Strobes from the sequencer to the edge unit
  typedef struct packed {
    logic query_start;
    logic load_prev;
    logic load_cur;
    logic mul_lhs;
    logic mul_rhs;
  } pip_ctrl_t;

endpackage

// ===== rtl/pip_in_if.sv =====
interface pip_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [2:0]         vertex_index;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;

  modport source (output valid, kind, vertex_index, point_x, point_y, input ready);
  modport sink   (input valid, kind, vertex_index, point_x, point_y, output ready);
endinterface

// ===== rtl/pip_out_if.sv =====
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// ===== rtl/pip_cfg_if.sv =====
interface pip_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== rtl/pip_ram.sv =====
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pip_edge_unit.sv =====
module pip_edge_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pip_pkg::pip_ctrl_t            ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic [2*COORD_WIDTH-1:0]      vertex_i,
  output logic                          inside_o
);
  import pip_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  logic signed [COORD_WIDTH-1:0] xp_q, yp_q;
  logic signed [COORD_WIDTH-1:0] xc_q, yc_q;
  logic signed [COORD_WIDTH-1:0] vx, vy;
  logic signed [DW-1:0]          op_a, op_b;
  logic signed [PW-1:0]          prod_q, lhs_q;
  logic                          spans, dpos;
  logic                          spans_q, dpos_q, pend_q, parity_q;
  logic                          left;

  assign vx = vertex_i[2*COORD_WIDTH-1:COORD_WIDTH];
  assign vy = vertex_i[COORD_WIDTH-1:0];

  // Shared multiplier operands: (x - xi)*(yj - yi), then (xj - xi)*(y - yi)
  always_comb begin
    if (ctrl_i.mul_lhs) begin
      op_a = DW'(px_q) - DW'(xc_q);
      op_b = DW'(yp_q) - DW'(yc_q);
    end else begin
      op_a = DW'(xp_q) - DW'(xc_q);
      op_b = DW'(py_q) - DW'(yc_q);
    end
  end

  // Edge spans the query y: lower end in, upper end out
  assign spans = ((yc_q <= py_q) && (py_q < yp_q)) || ((yp_q <= py_q) && (py_q < yc_q));
  assign dpos  = yp_q > yc_q;

  // Direction of the cross-multiplied compare follows the sign of dy
  assign left = dpos_q ? (lhs_q < prod_q) : (lhs_q > prod_q);

  // Payload registers: query point, vertex pair, edge flags, products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.query_start) begin
      px_q <= query_x_i;
      py_q <= query_y_i;
    end
    if (ctrl_i.load_prev) begin
      xp_q <= vx;
      yp_q <= vy;
    end else if (ctrl_i.mul_rhs) begin
      xp_q <= xc_q;
      yp_q <= yc_q;
    end
    if (ctrl_i.load_cur) begin
      xc_q <= vx;
      yc_q <= vy;
    end
    if (ctrl_i.mul_lhs) begin
      spans_q <= spans;
      dpos_q  <= dpos;
    end
    if (ctrl_i.mul_rhs) begin
      lhs_q <= prod_q;
    end
    if (ctrl_i.mul_lhs || ctrl_i.mul_rhs) begin
      prod_q <= op_a * op_b;
    end
  end

  // Parity resolves the cycle after the second product lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      pend_q <= ctrl_i.mul_rhs;
      if (ctrl_i.query_start) begin
        parity_q <= 1'b0;
      end else if (pend_q && spans_q && left) begin
        parity_q <= ~parity_q;
      end
    end
  end

  assign inside_o = parity_q;

endmodule

// ===== rtl/pip_ctrl.sv =====
module pip_ctrl #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_fire_i,
  input  logic [3:0]                      cfg_count_i,
  input  logic                            query_go_i,
  input  logic                            out_fire_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  output pip_pkg::pip_ctrl_t              ctrl_o,
  output logic [$clog2(MAX_VERTICES)-1:0] raddr_o
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  pip_state_e    state_q, state_d;
  logic [3:0]    count_q;
  logic [NW-1:0] n_q, n_sel;
  logic [AW-1:0] idx_q, idx_d, last;

  // Vertices in use, clipped to the table depth
  always_comb begin
    if (32'(count_q) > MAX_VERTICES) begin
      n_sel = NW'(MAX_VERTICES);
    end else begin
      n_sel = NW'(count_q);
    end
  end

  assign last = AW'(n_q - NW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_go_i) begin
          state_d = (n_sel == '0) ? ST_OUT : ST_START;
        end
      end
      ST_START:  state_d = ST_PRIME;
      ST_PRIME:  state_d = ST_FETCH;
      ST_FETCH:  state_d = ST_MUL_L;
      ST_MUL_L:  state_d = ST_MUL_R;
      ST_MUL_R:  state_d = (idx_q == last) ? ST_FINISH : ST_FETCH;
      ST_FINISH: state_d = ST_OUT;
      ST_OUT: begin
        if (out_fire_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs and read address
  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    raddr_o     = idx_q;
    idx_d       = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o         = 1'b1;
        ctrl_o.query_start = query_go_i;
        idx_d              = '0;
      end
      ST_START:  raddr_o = last;
      ST_PRIME: begin
        ctrl_o.load_prev = 1'b1;
        raddr_o          = '0;
      end
      ST_FETCH:  ctrl_o.load_cur = 1'b1;
      ST_MUL_L:  ctrl_o.mul_lhs = 1'b1;
      ST_MUL_R: begin
        ctrl_o.mul_rhs = 1'b1;
        idx_d          = idx_q + AW'(1);
        raddr_o        = idx_d;
      end
      ST_FINISH: ;
      ST_OUT:    out_valid_o = 1'b1;
      default:   ;
    endcase
  end

  // Sequencer and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= VERTEX_COUNT_RESET;
      n_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_fire_i) begin
        count_q <= cfg_count_i;
      end
      if (query_go_i) begin
        n_q <= n_sel;
      end
    end
  end

endmodule

// ===== rtl/point_in_polygon_test.sv =====
// Even-odd point-in-polygon tester. A vertex write (kind 0) stores a signed
// Q8.8 vertex at vertex_index and returns nothing; writes to a slot at or
// above MAX_VERTICES are dropped. A query (kind 1) returns one inside_res
// flag after walking the n = min(vertex_count, MAX_VERTICES) edges of the
// polygon. Each edge goes through a single shared multiplier twice
// (x - xi)*(yj - yi) and (xj - xi)*(y - yi), so each edge takes a vertex
// fetch plus two products; with a vertex count of zero the result is shown
// in the cycle straight after the query transfer. The block takes its next
// item in the cycle after the result is transferred. vertex_count is written
// on its own channel, which is always ready, and is only to be changed while
// no query is in flight.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 8,
  parameter int COORD_WIDTH  = 16
) (
  input logic   clk_i,
  input logic   rst_ni,
  pip_in_if.sink    in_i,
  pip_out_if.source out_o,
  pip_cfg_if.sink   cfg_i
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int IW = (AW > 3) ? AW : 3;

  logic                          in_fire, query_go, vertex_we, slot_ok;
  logic [IW-1:0]                 slot_ext;
  logic [AW-1:0]                 waddr, raddr;
  logic signed [COORD_WIDTH-1:0] px_c, py_c;
  logic [2*COORD_WIDTH-1:0]      vertex_rd;
  pip_ctrl_t                     ctrl;

  // Input decode
  assign in_fire   = in_i.valid && in_i.ready;
  assign query_go  = in_fire && (in_i.kind == KIND_QUERY);
  assign slot_ok   = 32'(in_i.vertex_index) < MAX_VERTICES;
  assign vertex_we = in_fire && (in_i.kind == KIND_WRITE) && slot_ok;
  assign slot_ext  = IW'(in_i.vertex_index);
  assign waddr     = slot_ext[AW-1:0];

  // Coordinates wrap or sign-extend to the stored width
  assign px_c = COORD_WIDTH'(in_i.point_x);
  assign py_c = COORD_WIDTH'(in_i.point_y);

  assign cfg_i.ready = 1'b1;

  pip_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (vertex_we),
    .waddr_i (waddr),
    .wdata_i ({px_c, py_c}),
    .raddr_i (raddr),
    .rdata_o (vertex_rd)
  );

  pip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_fire_i  (cfg_i.valid && cfg_i.ready),
    .cfg_count_i (cfg_i.vertex_count),
    .query_go_i  (query_go),
    .out_fire_i  (out_o.valid && out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctrl_o      (ctrl),
    .raddr_o     (raddr)
  );

  pip_edge_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .query_x_i (px_c),
    .query_y_i (py_c),
    .vertex_i  (vertex_rd),
    .inside_o  (out_o.inside_res)
  );

endmodule
